// ----- rtl/dcte_pkg.sv -----
package dcte_pkg;

  localparam int DATA_W = 32;
  localparam int COL_W  = 8;
  localparam int PTR_W  = 17;
  localparam int DIM_W  = 9;
  localparam int THR_W  = 31;
  localparam int SQ_W   = 2 * DATA_W;
  localparam int THRSQ_W = 2 * THR_W;

  localparam logic KIND_PTR   = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;

  localparam logic CFG_IDX_DIM = 1'b0;
  localparam logic CFG_IDX_THR = 1'b1;

  localparam int PEND_ROW   = 0;
  localparam int PEND_ENTRY = 1;
  localparam int PEND_FINAL = 2;

  typedef struct packed {
    logic             first_col;
    logic             mat_end;
    logic [COL_W-1:0] col;
  } tag_t;

  typedef struct packed {
    tag_t                     tag;
    logic                     keep;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } item_t;

endpackage

// ----- rtl/dcte_mag.sv -----
module dcte_mag
  import dcte_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_re,
  input  logic signed [DATA_W-1:0] in_im,
  input  tag_t                     in_tag,
  input  logic [THRSQ_W-1:0]       thr_sq,
  output logic                     item_valid,
  input  logic                     item_take,
  output item_t                    item
);

  logic                     v1_r, v2_r, v3_r;
  logic                     ld1, ld2, ld3;
  logic signed [DATA_W-1:0] re1_r, im1_r, re2_r, im2_r;
  tag_t                     tag1_r, tag2_r;
  logic [DATA_W-1:0]        abs_re, abs_im;
  logic [SQ_W-1:0]          sq_re_nxt, sq_im_nxt, sq_re_r, sq_im_r;
  logic [SQ_W:0]            mag_sum;
  logic                     keep_nxt;
  item_t                    item_r;

  assign ld3      = !v3_r || item_take;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_ready = ld1;

  always_comb begin
    abs_re    = re1_r[DATA_W-1] ? (DATA_W'(0) - $unsigned(re1_r)) : $unsigned(re1_r);
    abs_im    = im1_r[DATA_W-1] ? (DATA_W'(0) - $unsigned(im1_r)) : $unsigned(im1_r);
    sq_re_nxt = SQ_W'(abs_re) * SQ_W'(abs_re);
    sq_im_nxt = SQ_W'(abs_im) * SQ_W'(abs_im);
    mag_sum   = {1'b0, sq_re_r} + {1'b0, sq_im_r};
    keep_nxt  = mag_sum > (SQ_W + 1)'(thr_sq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      re1_r  <= in_re;
      im1_r  <= in_im;
      tag1_r <= in_tag;
    end
    if (ld2) begin
      re2_r   <= re1_r;
      im2_r   <= im1_r;
      tag2_r  <= tag1_r;
      sq_re_r <= sq_re_nxt;
      sq_im_r <= sq_im_nxt;
    end
    if (ld3) begin
      item_r.tag  <= tag2_r;
      item_r.keep <= keep_nxt;
      item_r.re   <= re2_r;
      item_r.im   <= im2_r;
    end
  end

  assign item_valid = v3_r;
  assign item       = item_r;

endmodule

// ----- rtl/dcte_emit.sv -----
module dcte_emit
  import dcte_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     item_valid,
  output logic                     item_take,
  input  item_t                    item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_record_kind,
  output logic [COL_W-1:0]         out_column_index,
  output logic signed [DATA_W-1:0] out_value_real,
  output logic signed [DATA_W-1:0] out_value_imag,
  output logic [PTR_W-1:0]         out_row_pointer,
  output logic                     out_last_of_run
);

  logic                     hv_r;
  logic [2:0]               pend_r, pend_in, sel, pend_left;
  logic [COL_W-1:0]         col_r;
  logic signed [DATA_W-1:0] re_r, im_r;
  logic [PTR_W-1:0]         kept_r, kept_nxt;
  logic                     out_valid_r, out_load, emit, done;
  logic                     kind_nxt;
  logic [COL_W-1:0]         col_nxt;
  logic signed [DATA_W-1:0] re_nxt, im_nxt;
  logic [PTR_W-1:0]         ptr_nxt;
  logic                     kind_r, last_r;
  logic [COL_W-1:0]         ocol_r;
  logic signed [DATA_W-1:0] ore_r, oim_r;
  logic [PTR_W-1:0]         optr_r;

  assign pend_in = {item.tag.mat_end, item.keep, item.tag.first_col};

  always_comb begin
    out_load = !out_valid_r || out_ready;
    emit     = hv_r && out_load;
    sel      = '0;
    kind_nxt = KIND_PTR;
    col_nxt  = '0;
    re_nxt   = '0;
    im_nxt   = '0;
    ptr_nxt  = kept_r;
    kept_nxt = kept_r;
    priority if (pend_r[PEND_ROW]) begin
      sel[PEND_ROW] = 1'b1;
    end else if (pend_r[PEND_ENTRY]) begin
      sel[PEND_ENTRY] = 1'b1;
      kind_nxt        = KIND_ENTRY;
      col_nxt         = col_r;
      re_nxt          = re_r;
      im_nxt          = im_r;
      ptr_nxt         = '0;
      kept_nxt        = kept_r + PTR_W'(1);
    end else begin
      sel[PEND_FINAL] = 1'b1;
      kept_nxt        = '0;
    end
    pend_left = pend_r & ~sel;
    done      = emit && (pend_left == '0);
    item_take = !hv_r || done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r        <= 1'b0;
      pend_r      <= '0;
      kept_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (item_take) begin
        hv_r   <= item_valid && (pend_in != '0);
        pend_r <= pend_in;
      end else if (emit) begin
        pend_r <= pend_left;
      end
      if (emit) kept_r <= kept_nxt;
      if (out_load) out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      col_r <= item.tag.col;
      re_r  <= item.re;
      im_r  <= item.im;
    end
    if (emit) begin
      kind_r <= kind_nxt;
      ocol_r <= col_nxt;
      ore_r  <= re_nxt;
      oim_r  <= im_nxt;
      optr_r <= ptr_nxt;
      last_r <= (pend_left == '0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_record_kind  = kind_r;
  assign out_column_index = ocol_r;
  assign out_value_real   = ore_r;
  assign out_value_imag   = oim_r;
  assign out_row_pointer  = optr_r;
  assign out_last_of_run  = last_r;

endmodule

// ----- rtl/dense_to_csr_threshold_encoder.sv -----
// Streams a square complex matrix, one element per transaction in row-major order, and
// produces its compressed sparse row form as a stream of records: a row pointer at the
// start of each row, an entry record for each element whose squared magnitude exceeds
// the squared threshold, and a closing row pointer holding the total count after the last
// element. An element passes through three pipeline stages (input register, squaring,
// compare) and then the record expander. A new element is taken every cycle while the
// output does not stall; the single output register sends one record per cycle while
// out_ready is high, so an element that yields n records (at most three) holds the
// expander until they are sent, and one that yields none costs nothing beyond its pipeline slot.
// Writes to matrix_dim or mag_threshold must be made only while the block is empty.
module dense_to_csr_threshold_encoder
  import dcte_pkg::*;
#(
  parameter int MAX_DIM = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [THR_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_elem_real,
  input  logic signed [DATA_W-1:0] in_elem_imag,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_record_kind,
  output logic [COL_W-1:0]         out_column_index,
  output logic signed [DATA_W-1:0] out_value_real,
  output logic signed [DATA_W-1:0] out_value_imag,
  output logic [PTR_W-1:0]         out_row_pointer,
  output logic                     out_last_of_run
);

  localparam int DimLim = (MAX_DIM < 256) ? MAX_DIM : 256;

  logic [DIM_W-1:0]   dim_r, dim_eff;
  logic [THR_W-1:0]   thr_r;
  logic [THRSQ_W-1:0] thr_sq_r;
  logic [COL_W-1:0]   row_r, col_r, last_idx;
  logic               row_end, mat_end, in_acc;
  tag_t               in_tag;
  logic               item_valid, item_take;
  item_t              item;

  always_comb begin
    dim_eff = (dim_r == '0) ? DIM_W'(1) : dim_r;
    if (dim_eff > DIM_W'(DimLim)) dim_eff = DIM_W'(DimLim);
    last_idx         = COL_W'(dim_eff - DIM_W'(1));
    row_end          = col_r >= last_idx;
    mat_end          = row_end && (row_r >= last_idx);
    in_tag.first_col = (col_r == '0);
    in_tag.mat_end   = mat_end;
    in_tag.col       = col_r;
    in_acc           = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r    <= DIM_W'(1);
      thr_r    <= '0;
      thr_sq_r <= '0;
      row_r    <= '0;
      col_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IDX_DIM: dim_r <= cfg_wdata[DIM_W-1:0];
          CFG_IDX_THR: thr_r <= cfg_wdata;
        endcase
      end
      thr_sq_r <= THRSQ_W'(thr_r) * THRSQ_W'(thr_r);
      if (in_acc) begin
        if (mat_end) begin
          row_r <= '0;
          col_r <= '0;
        end else if (row_end) begin
          col_r <= '0;
          row_r <= row_r + COL_W'(1);
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end
    end
  end

  dcte_mag u_mag (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_re      (in_elem_real),
    .in_im      (in_elem_imag),
    .in_tag     (in_tag),
    .thr_sq     (thr_sq_r),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item)
  );

  dcte_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item_valid),
    .item_take        (item_take),
    .item             (item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_record_kind  (out_record_kind),
    .out_column_index (out_column_index),
    .out_value_real   (out_value_real),
    .out_value_imag   (out_value_imag),
    .out_row_pointer  (out_row_pointer),
    .out_last_of_run  (out_last_of_run)
  );

`ifndef SYNTH
  a_mat_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && mat_end |=> row_r == '0 && col_r == '0)
    else $error("counters not cleared after the last element of a matrix");

  a_entry_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind == KIND_ENTRY |-> out_row_pointer == '0)
    else $error("entry record carries a row pointer");

  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid)
    else $error("records of one transaction were not sent back to back");
`endif

endmodule
